>>> hdl/assert_macros.svh
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/smm_pkg.sv
package smm_pkg;

  localparam int SIZE_W   = 5;
  localparam int ROW_W    = 4;
  localparam int COL_W    = 4;
  localparam int KIND_W   = 2;
  localparam int ELEM_IN_W = 16;
  localparam int ACC_W    = 32;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam logic [KIND_W-1:0] KIND_LOAD_LEFT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_RIGHT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE    = 2'd2;

  localparam logic REG_MATRIX_SIZE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } smm_state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic issue;
    logic emit;
    logic last;
  } smm_cmd_t;

endpackage

>>> hdl/square_matrix_multiply.sv
// channel   direction  transfer condition              payload
// input     in         start && !busy                  in_kind in_row in_col in_element_value
// result    out        out_valid (one cycle, no stall) out_col out_product_value out_last_of_row
// config    apb        psel && penable && pwrite       paddr pwdata, prdata on reads
//
// a load item is written into its store as it is accepted; busy stays low and the next item may follow at once
// a compute item holds busy (n = min(matrix_size, MAX_SIZE)) through n reads from
// the single left store feeding one mac per column, then the read/multiply pipeline
// fill, then one result per cycle
// rst_n is synchronous; matrix stores are not cleared and hold garbage until written
// results cannot be stalled; each strobe lasts exactly one cycle
`include "assert_macros.svh"

module square_matrix_multiply import smm_pkg::*; #(
  parameter int MAX_SIZE     = 16,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [KIND_W-1:0]           in_kind,
  input  logic [ROW_W-1:0]            in_row,
  input  logic [COL_W-1:0]            in_col,
  input  logic signed [ELEM_IN_W-1:0] in_element_value,
  output logic                        out_valid,
  output logic [COL_W-1:0]            out_col,
  output logic signed [ACC_W-1:0]     out_product_value,
  output logic                        out_last_of_row,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [CFG_AW-1:0]           paddr,
  input  logic [CFG_DW-1:0]           pwdata,
  output logic [CFG_DW-1:0]           prdata,
  output logic                        pready
);

  localparam int IDX_W = $clog2(MAX_SIZE);
  localparam int N_W   = $clog2(MAX_SIZE + 1);

  logic [SIZE_W-1:0] size_r;
  logic [N_W-1:0]    n_eff;
  logic              item_accept;
  logic              pipe_empty;
  logic              cfg_wr;
  smm_cmd_t          cmd;
  logic [IDX_W-1:0]  cmd_idx;
  logic              compute_req;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign item_accept = start && !busy;
  assign prdata      = (paddr[2] == REG_MATRIX_SIZE) ? CFG_DW'(size_r) : '0;
  assign n_eff       = (32'(size_r) > MAX_SIZE) ? N_W'(MAX_SIZE) : N_W'(size_r);
  assign compute_req = item_accept && (in_kind == KIND_COMPUTE) &&
                       (32'(in_row) < 32'(n_eff));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_wr && (paddr[2] == REG_MATRIX_SIZE)) begin
      size_r <= pwdata[SIZE_W-1:0];
    end
  end

  smm_ctrl #(
    .MAX_SIZE (MAX_SIZE),
    .IDX_W    (IDX_W),
    .N_W      (N_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_accept (item_accept),
    .in_kind     (in_kind),
    .in_row      (in_row),
    .n_eff       (n_eff),
    .pipe_empty  (pipe_empty),
    .busy        (busy),
    .cmd         (cmd),
    .cmd_idx     (cmd_idx)
  );

  smm_datapath #(
    .MAX_SIZE     (MAX_SIZE),
    .ELEMENT_BITS (ELEMENT_BITS),
    .IDX_W        (IDX_W),
    .N_W          (N_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_accept       (item_accept),
    .in_kind           (in_kind),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_element_value  (in_element_value),
    .n_eff             (n_eff),
    .cmd               (cmd),
    .cmd_idx           (cmd_idx),
    .pipe_empty        (pipe_empty),
    .out_valid         (out_valid),
    .out_col           (out_col),
    .out_product_value (out_product_value),
    .out_last_of_row   (out_last_of_row)
  );

  `AST_NEXT(a_last_gap, clk, rst_n, out_valid && out_last_of_row, !out_valid)
  `AST_NEXT(a_compute_busy, clk, rst_n, compute_req, busy)
  `AST_IMPLY(a_idle_empty, clk, rst_n, !busy, pipe_empty)
  `AST_IMPLY(a_emit_busy, clk, rst_n, cmd.emit, busy && pipe_empty)

endmodule

>>> hdl/smm_ctrl.sv
module smm_ctrl import smm_pkg::*; #(
  parameter int MAX_SIZE = 16,
  parameter int IDX_W    = $clog2(MAX_SIZE),
  parameter int N_W      = $clog2(MAX_SIZE + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_accept,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [N_W-1:0]    n_eff,
  input  logic              pipe_empty,
  output logic              busy,
  output smm_cmd_t          cmd,
  output logic [IDX_W-1:0]  cmd_idx
);

  smm_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_last;
  logic             compute_go;

  assign compute_go = item_accept && (in_kind == KIND_COMPUTE) &&
                      (32'(in_row) < 32'(n_eff));
  assign cnt_last   = ((N_W'(cnt_r) + N_W'(1)) == n_eff);
  assign busy       = (state_r != ST_IDLE);
  assign cmd_idx    = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (compute_go) begin
          cmd.capture = 1'b1;
          cmd.clear   = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.last = cnt_last;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> hdl/smm_datapath.sv
module smm_datapath import smm_pkg::*; #(
  parameter int MAX_SIZE     = 16,
  parameter int ELEMENT_BITS = 16,
  parameter int IDX_W        = $clog2(MAX_SIZE),
  parameter int N_W          = $clog2(MAX_SIZE + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_accept,
  input  logic [KIND_W-1:0]          in_kind,
  input  logic [ROW_W-1:0]           in_row,
  input  logic [COL_W-1:0]           in_col,
  input  logic signed [ELEM_IN_W-1:0] in_element_value,
  input  logic [N_W-1:0]             n_eff,
  input  smm_cmd_t                   cmd,
  input  logic [IDX_W-1:0]           cmd_idx,
  output logic                       pipe_empty,
  output logic                       out_valid,
  output logic [COL_W-1:0]           out_col,
  output logic signed [ACC_W-1:0]    out_product_value,
  output logic                       out_last_of_row
);

  localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [ELEMENT_BITS-1:0] left_mem [DEPTH];
  logic [ELEMENT_BITS-1:0] left_rd_r;
  logic [ELEMENT_BITS-1:0] lane_rd_r [MAX_SIZE];
  logic [ACC_W-1:0]        prod_r [MAX_SIZE];
  logic [ACC_W-1:0]        acc_r [MAX_SIZE];

  logic [ROW_W-1:0]        row_r;
  logic                    s1_vld_r, s2_vld_r;

  logic                    in_range;
  logic                    wr_left, wr_right;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  logic [ACC_W-1:0]        elem_ext;
  logic [ELEMENT_BITS-1:0] elem_w;
  logic [ACC_W-1:0]        left_ext;

  assign in_range = (32'(in_row) < 32'(n_eff)) && (32'(in_col) < 32'(n_eff));
  assign wr_left  = item_accept && (in_kind == KIND_LOAD_LEFT) && in_range;
  assign wr_right = item_accept && (in_kind == KIND_LOAD_RIGHT) && in_range;
  assign wr_addr  = ADDR_W'(32'(in_row) * MAX_SIZE + 32'(in_col));
  assign rd_addr  = ADDR_W'(32'(row_r) * MAX_SIZE + 32'(cmd_idx));
  assign elem_ext = ACC_W'(in_element_value);
  assign elem_w   = elem_ext[ELEMENT_BITS-1:0];
  assign left_ext = ACC_W'(signed'(left_rd_r));
  assign pipe_empty = !s1_vld_r && !s2_vld_r;

  // left store, one row element per cycle
  always_ff @(posedge clk) begin
    if (wr_left) begin
      left_mem[wr_addr] <= elem_w;
    end
    if (cmd.issue) begin
      left_rd_r <= left_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  // one right column store and one mac per lane
  for (genvar j = 0; j < MAX_SIZE; j++) begin : g_lane
    logic [ELEMENT_BITS-1:0] lane_mem [MAX_SIZE];
    logic [ACC_W-1:0]        lane_ext;
    logic                    lane_sel;
    logic [ACC_W-1:0]        acc_shift;

    assign lane_sel = (32'(in_col) == j);
    assign lane_ext = ACC_W'(signed'(lane_rd_r[j]));

    if (j == MAX_SIZE - 1) begin : g_tail
      assign acc_shift = '0;
    end else begin : g_body
      assign acc_shift = acc_r[j + 1];
    end

    always_ff @(posedge clk) begin
      if (wr_right && lane_sel) begin
        lane_mem[IDX_W'(in_row)] <= elem_w;
      end
      if (cmd.issue) begin
        lane_rd_r[j] <= lane_mem[cmd_idx];
      end
    end

    always_ff @(posedge clk) begin
      if (s1_vld_r) begin
        prod_r[j] <= left_ext * lane_ext;
      end
    end

    // accumulators shift toward lane zero while the row is sent
    always_ff @(posedge clk) begin
      if (cmd.clear) begin
        acc_r[j] <= '0;
      end else if (s2_vld_r) begin
        acc_r[j] <= acc_r[j] + prod_r[j];
      end else if (cmd.emit) begin
        acc_r[j] <= acc_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_col           <= COL_W'(cmd_idx);
      out_product_value <= acc_r[0];
      out_last_of_row   <= cmd.last;
    end
  end

endmodule
